[rtl/assert_macros.svh]
// assertion macros used by the text terminal writer unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/ttw_pkg.sv]
// shared constants and types of the text terminal writer
`default_nettype none

package ttw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam int OP_W    = 2;
    localparam int CHAR_W  = 8;
    localparam int IDX_W   = 11;
    localparam int COL_W   = 7;
    localparam int LINE_W  = 5;
    localparam int CELL_W  = 16;
    localparam int ATTR_W  = 8;

    typedef enum logic [OP_W-1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    localparam logic [CHAR_W-1:0] CHAR_BLANK  = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_BS     = 8'h08;
    localparam logic [CHAR_W-1:0] CHAR_NL     = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_VIS_LO = 8'h21;
    localparam logic [CHAR_W-1:0] CHAR_VIS_HI = 8'h7E;
    localparam logic [ATTR_W-1:0] ATTR_RESET  = 8'h07;

endpackage

`default_nettype wire

[rtl/ttw_channels_if.sv]
// request and response channel interfaces of the text terminal writer
`default_nettype none

interface ttw_req_if;
    import ttw_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [CHAR_W-1:0]   char_code;
    logic [IDX_W-1:0]    cell_index;

    modport source (output valid, output operation, output char_code, output cell_index,
                    input ready);
    modport sink   (input valid, input operation, input char_code, input cell_index,
                    output ready);
endinterface

interface ttw_resp_if;
    import ttw_pkg::*;

    logic                valid;
    logic                ready;
    logic [COL_W-1:0]    cursor_column;
    logic [LINE_W-1:0]   cursor_line;
    logic [CELL_W-1:0]   read_data;
    logic                scrolled;

    modport source (output valid, output cursor_column, output cursor_line,
                    output read_data, output scrolled, input ready);
    modport sink   (input valid, input cursor_column, input cursor_line,
                    input read_data, input scrolled, output ready);
endinterface

`default_nettype wire

[rtl/ttw_ram.sv]
// generic single write port, single read port ram with registered read
`default_nettype none

module ttw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/text_terminal_writer_unit.sv]
// text terminal writer: screen store, cursor and request sequencer
`default_nettype none
`include "assert_macros.svh"

// Character-cell text terminal of COLUMNS x ROWS 16-bit cells (attribute in the
// high byte, character in the low byte) held in one ram with a single write and a
// single registered read port. One request is worked at a time; a finished response
// sits in an output register so the next request can be taken while it waits.
// A put that scrolls walks the ram once: it copies each cell up by one row, lets the
// last copy drain, then blanks the bottom row. A clear writes every cell, one per
// cycle. After reset a clearing pass fills the store with blank cells; requests
// are not taken during it, the attribute register can be written as ever.
module text_terminal_writer_unit #(
    parameter int COLUMNS = ttw_pkg::COLUMNS_DEF,
    parameter int ROWS    = ttw_pkg::ROWS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [ttw_pkg::ATTR_W-1:0]  cfg_wdata,
    ttw_req_if.sink                          req,
    ttw_resp_if.source                       resp
);
    import ttw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int IW    = (AW > IDX_W) ? AW : IDX_W;

    typedef enum logic [2:0] {
        S_FILL,
        S_IDLE,
        S_PUT,
        S_SCROLL,
        S_BLANK,
        S_READ,
        S_DONE
    } state_t;

    state_t                state_reg;
    logic [CW-1:0]         col_reg;
    logic [RW-1:0]         row_reg;
    logic [ATTR_W-1:0]     attr_reg;
    logic [ATTR_W-1:0]     fill_attr_reg;
    logic                  init_reg;
    logic [AW-1:0]         ptr_reg;
    logic [AW-1:0]         copy_dst_reg;
    logic                  copy_valid_reg;
    logic [CHAR_W-1:0]     char_reg;
    logic [CELL_W-1:0]     res_data_reg;
    logic                  res_scrolled_reg;
    logic                  out_valid_reg;
    logic [COL_W-1:0]      out_col_reg;
    logic [LINE_W-1:0]     out_line_reg;
    logic [CELL_W-1:0]     out_data_reg;
    logic                  out_scrolled_reg;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [CELL_W-1:0]     ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [CELL_W-1:0]     ram_rdata;

    logic                  accept;
    logic [IW-1:0]         idx_ext;
    logic                  idx_ok;
    logic                  visible;
    logic [AW-1:0]         cursor_addr;
    logic                  out_free;

    ttw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign idx_ext   = IW'(req.cell_index);
    assign idx_ok    = (idx_ext < IW'(CELLS));
    assign visible   = (char_reg >= CHAR_VIS_LO) && (char_reg <= CHAR_VIS_HI);
    assign cursor_addr = AW'(row_reg * COLUMNS + col_reg);
    assign out_free  = !out_valid_reg || resp.ready;

    // read port: request cell on acceptance, copy source during scroll
    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            ram_raddr = idx_ext[AW-1:0];
        end
        else
        begin
            ram_raddr = AW'(ptr_reg + COLUMNS);
        end
    end

    // write port: pending copy first, then sweeps, then the put itself
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = ptr_reg;
        ram_wdata = {attr_reg, CHAR_BLANK};
        priority if (copy_valid_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = copy_dst_reg;
            ram_wdata = ram_rdata;
        end
        else if (state_reg == S_FILL)
        begin
            ram_we    = 1'b1;
            ram_wdata = {fill_attr_reg, CHAR_BLANK};
        end
        else if (state_reg == S_BLANK)
        begin
            ram_we    = 1'b1;
        end
        else if (state_reg == S_PUT)
        begin
            ram_we    = visible;
            ram_waddr = cursor_addr;
            ram_wdata = {attr_reg, char_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_FILL;
            col_reg          <= '0;
            row_reg          <= '0;
            attr_reg         <= ATTR_RESET;
            fill_attr_reg    <= ATTR_RESET;
            init_reg         <= 1'b1;
            ptr_reg          <= '0;
            copy_valid_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                attr_reg <= cfg_wdata;
            end

            // the done state reloads the output register itself
            if (resp.ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            copy_valid_reg <= (state_reg == S_SCROLL);
            copy_dst_reg   <= ptr_reg;

            unique case (state_reg)
                S_FILL:
                begin
                    ptr_reg <= ptr_reg + 1'b1;
                    if (ptr_reg == AW'(CELLS - 1))
                    begin
                        init_reg  <= 1'b0;
                        state_reg <= init_reg ? S_IDLE : S_DONE;
                    end
                end

                S_IDLE:
                begin
                    if (accept)
                    begin
                        char_reg         <= req.char_code;
                        res_data_reg     <= '0;
                        res_scrolled_reg <= 1'b0;
                        unique case (op_t'(req.operation))
                            OP_PUT:
                            begin
                                state_reg <= S_PUT;
                            end
                            OP_CLEAR:
                            begin
                                fill_attr_reg <= attr_reg;
                                ptr_reg       <= '0;
                                col_reg       <= '0;
                                row_reg       <= '0;
                                state_reg     <= S_FILL;
                            end
                            OP_READ:
                            begin
                                state_reg <= idx_ok ? S_READ : S_DONE;
                            end
                            OP_NONE:
                            begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end

                S_PUT:
                begin
                    priority if (char_reg == CHAR_BS)
                    begin
                        state_reg <= S_DONE;
                        if (col_reg != '0)
                        begin
                            col_reg <= col_reg - 1'b1;
                        end
                    end
                    else if ((col_reg == CW'(COLUMNS - 1)) || (char_reg == CHAR_NL))
                    begin
                        col_reg <= '0;
                        if (row_reg == RW'(ROWS - 1))
                        begin
                            res_scrolled_reg <= 1'b1;
                            ptr_reg          <= '0;
                            state_reg        <= S_SCROLL;
                        end
                        else
                        begin
                            row_reg   <= row_reg + 1'b1;
                            state_reg <= S_DONE;
                        end
                    end
                    else
                    begin
                        col_reg   <= col_reg + 1'b1;
                        state_reg <= S_DONE;
                    end
                end

                S_SCROLL:
                begin
                    // read ptr+COLUMNS now, its data is written to ptr next cycle
                    ptr_reg <= ptr_reg + 1'b1;
                    if (ptr_reg == AW'(CELLS - COLUMNS - 1))
                    begin
                        state_reg <= S_BLANK;
                    end
                end

                S_BLANK:
                begin
                    // first cycle only drains the last row copy
                    if (!copy_valid_reg)
                    begin
                        ptr_reg <= ptr_reg + 1'b1;
                        if (ptr_reg == AW'(CELLS - 1))
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                end

                S_READ:
                begin
                    res_data_reg <= ram_rdata;
                    state_reg    <= S_DONE;
                end

                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg    <= 1'b1;
                        out_col_reg      <= COL_W'(col_reg);
                        out_line_reg     <= LINE_W'(row_reg);
                        out_data_reg     <= res_data_reg;
                        out_scrolled_reg <= res_scrolled_reg;
                        state_reg        <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign resp.valid         = out_valid_reg;
    assign resp.cursor_column = out_col_reg;
    assign resp.cursor_line   = out_line_reg;
    assign resp.read_data     = out_data_reg;
    assign resp.scrolled      = out_scrolled_reg;

    `ASSERT_ALWAYS(a_cursor_range, clk, rst_n,
        (col_reg <= CW'(COLUMNS - 1)) && (row_reg <= RW'(ROWS - 1)),
        "cursor outside the screen")
    `ASSERT_NEXT(a_busy_after_request, clk, rst_n, req.valid && req.ready, !req.ready,
        "request taken while another is in work")
    `ASSERT_IMPLIES(a_scroll_cursor, clk, rst_n, resp.valid && resp.scrolled,
        (resp.cursor_line == LINE_W'(ROWS - 1)) && (resp.cursor_column == '0),
        "scroll response without cursor at start of bottom row")

endmodule

`default_nettype wire

[bench/text_terminal_writer_unit_tb.sv]
// testbench of the text terminal writer: directed table, random requests, scoreboard
`timescale 1ns / 100ps

module text_terminal_writer_unit_tb;
    import ttw_pkg::*;

    localparam int CELL_COUNT  = COLUMNS_DEF * ROWS_DEF;
    localparam int IDLE_LIMIT  = 20000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 212;

    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [LINE_W-1:0] line;
        logic [CELL_W-1:0] data;
        logic              scrolled;
    } term_reply_t;

    // one row of the directed table; the typed reply applies to the last repeat
    typedef struct packed {
        op_t               op;
        logic [CHAR_W-1:0] ch;
        logic [IDX_W-1:0]  idx;
        logic [6:0]        reps;
        logic              typed;
        term_reply_t       want;
    } step_row_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [ATTR_W-1:0]   cfg_wdata;

    ttw_req_if  req_ch ();
    ttw_resp_if resp_ch ();

    text_terminal_writer_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .resp      (resp_ch)
    );

    // shadow of the screen, cursor and attribute
    logic [CELL_W-1:0] screen_copy [CELL_COUNT];
    int unsigned       cur_col;
    int unsigned       cur_row;
    logic [ATTR_W-1:0] attribute;

    term_reply_t awaited_replies [$];

    int  fail_count;
    int  request_count;
    int  read_count;
    int  scroll_count;
    int  clear_count;
    int  attr_writes;
    int  stall_left;
    bit  quiet;

    step_row_t directed_steps [0:25] = '{
        '{OP_READ,  8'h00, 11'd0,    7'd1,  1'b1, '{7'd0, 5'd0,  16'h0720, 1'b0}},
        '{OP_READ,  8'h00, 11'd1999, 7'd1,  1'b1, '{7'd0, 5'd0,  16'h0720, 1'b0}},
        '{OP_READ,  8'h00, 11'd2000, 7'd1,  1'b1, '{7'd0, 5'd0,  16'h0000, 1'b0}},
        '{OP_READ,  8'hFF, 11'd2047, 7'd1,  1'b1, '{7'd0, 5'd0,  16'h0000, 1'b0}},
        '{OP_NONE,  8'hFF, 11'd2047, 7'd1,  1'b1, '{7'd0, 5'd0,  16'h0000, 1'b0}},
        '{OP_PUT,   8'h41, 11'd0,    7'd1,  1'b1, '{7'd1, 5'd0,  16'h0000, 1'b0}},
        '{OP_PUT,   8'h21, 11'd0,    7'd1,  1'b0, '0},
        '{OP_PUT,   8'h7E, 11'd0,    7'd1,  1'b0, '0},
        '{OP_PUT,   8'h20, 11'd0,    7'd1,  1'b0, '0},
        '{OP_PUT,   8'h7F, 11'd0,    7'd1,  1'b0, '0},
        '{OP_PUT,   8'hFF, 11'd0,    7'd1,  1'b0, '0},
        '{OP_PUT,   8'h00, 11'd0,    7'd1,  1'b0, '0},
        '{OP_PUT,   8'h08, 11'd0,    7'd1,  1'b0, '0},
        '{OP_READ,  8'h00, 11'd0,    7'd1,  1'b1, '{7'd6, 5'd0,  16'h0741, 1'b0}},
        '{OP_READ,  8'h00, 11'd2,    7'd1,  1'b0, '0},
        '{OP_PUT,   8'h0A, 11'd0,    7'd1,  1'b1, '{7'd0, 5'd1,  16'h0000, 1'b0}},
        // backspace at column 0 stays put
        '{OP_PUT,   8'h08, 11'd0,    7'd1,  1'b1, '{7'd0, 5'd1,  16'h0000, 1'b0}},
        '{OP_PUT,   8'h5A, 11'd0,    7'd79, 1'b0, '0},
        // last column wraps to the next row
        '{OP_PUT,   8'h5A, 11'd0,    7'd1,  1'b1, '{7'd0, 5'd2,  16'h0000, 1'b0}},
        '{OP_PUT,   8'h0A, 11'd0,    7'd22, 1'b1, '{7'd0, 5'd24, 16'h0000, 1'b0}},
        '{OP_PUT,   8'h0A, 11'd0,    7'd1,  1'b1, '{7'd0, 5'd24, 16'h0000, 1'b1}},
        '{OP_READ,  8'h00, 11'd79,   7'd1,  1'b1, '{7'd0, 5'd24, 16'h075A, 1'b0}},
        '{OP_READ,  8'h00, 11'd1999, 7'd1,  1'b1, '{7'd0, 5'd24, 16'h0720, 1'b0}},
        '{OP_PUT,   8'h33, 11'd0,    7'd80, 1'b0, '0},
        '{OP_CLEAR, 8'h00, 11'd0,    7'd1,  1'b1, '{7'd0, 5'd0,  16'h0000, 1'b0}},
        '{OP_READ,  8'h00, 11'd1000, 7'd1,  1'b1, '{7'd0, 5'd0,  16'h0720, 1'b0}}
    };

    logic [ATTR_W-1:0] phase_attrs [PHASES] = '{8'hFF, 8'h00, 8'h5C, 8'h0F,
                                               8'hF0, 8'h3A, 8'hC4, ATTR_RESET};

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic term_reply_t apply_terminal_op(op_t op, logic [CHAR_W-1:0] ch,
                                                      logic [IDX_W-1:0] idx);
        term_reply_t r;
        int          i;
        r = '0;
        request_count++;
        case (op)
            OP_PUT:
            begin
                if (ch >= CHAR_VIS_LO && ch <= CHAR_VIS_HI)
                    screen_copy[cur_row * COLUMNS_DEF + cur_col] = {attribute, ch};
                if (ch == CHAR_BS)
                begin
                    if (cur_col > 0)
                        cur_col--;
                end
                else
                begin
                    cur_col++;
                    if (cur_col >= COLUMNS_DEF || ch == CHAR_NL)
                    begin
                        cur_col = 0;
                        cur_row++;
                        if (cur_row >= ROWS_DEF)
                        begin
                            for (i = 0; i < CELL_COUNT - COLUMNS_DEF; i++)
                                screen_copy[i] = screen_copy[i + COLUMNS_DEF];
                            for (i = CELL_COUNT - COLUMNS_DEF; i < CELL_COUNT; i++)
                                screen_copy[i] = {attribute, CHAR_BLANK};
                            cur_row    = ROWS_DEF - 1;
                            r.scrolled = 1'b1;
                            scroll_count++;
                        end
                    end
                end
            end
            OP_CLEAR:
            begin
                for (i = 0; i < CELL_COUNT; i++)
                    screen_copy[i] = {attribute, CHAR_BLANK};
                cur_col = 0;
                cur_row = 0;
                clear_count++;
            end
            OP_READ:
            begin
                if (idx < CELL_COUNT)
                    r.data = screen_copy[idx];
                read_count++;
            end
            default: ;
        endcase
        r.col  = COL_W'(cur_col);
        r.line = LINE_W'(cur_row);
        return r;
    endfunction

    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (quiet || sel < 65)
            return 0;
        else if (sel < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 50);
    endfunction

    task automatic pick_request(output op_t op, output logic [CHAR_W-1:0] ch,
                                output logic [IDX_W-1:0] idx);
        int sel;
        int how;
        sel = $urandom_range(0, 99);
        how = $urandom_range(0, 99);
        ch  = CHAR_W'($urandom);
        idx = IDX_W'($urandom);
        op  = OP_PUT;
        if (sel < 55 || sel >= 93)
            ch = CHAR_W'($urandom_range(CHAR_VIS_LO, CHAR_VIS_HI));
        else if (sel < 63)
            ch = CHAR_NL;
        else if (sel < 68)
            ch = CHAR_BS;
        else if (sel < 74)
            ch = CHAR_W'($urandom);
        else if (sel < 90)
        begin
            op = OP_READ;
            // half of the reads go to the cursor row, where text was just written
            if (how < 50)
                idx = IDX_W'(cur_row * COLUMNS_DEF + $urandom_range(0, COLUMNS_DEF - 1));
            else if (how < 85)
                idx = IDX_W'($urandom_range(0, CELL_COUNT - 1));
        end
        else if (sel < 91)
            op = OP_CLEAR;
        else
            op = OP_NONE;
    endtask

    task automatic issue_request(op_t op, logic [CHAR_W-1:0] ch, logic [IDX_W-1:0] idx,
                                 bit typed, term_reply_t want, int gap);
        term_reply_t predicted;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.operation  <= op;
        req_ch.char_code  <= ch;
        req_ch.cell_index <= idx;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predicted = apply_terminal_op(op, ch, idx);
        awaited_replies.push_back(typed ? want : predicted);
    endtask

    task automatic wait_for_replies();
        req_ch.valid <= 1'b0;
        while (awaited_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_attribute(logic [ATTR_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        attribute = value;
        attr_writes++;
    endtask

    // response side: random stalls, with quiet phases always ready
    always @(posedge clk)
    begin
        int sel;
        sel = $urandom_range(0, 99);
        if (!rst_n)
            resp_ch.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            resp_ch.ready <= 1'b0;
            stall_left--;
        end
        else if (quiet || sel < 70)
            resp_ch.ready <= 1'b1;
        else
        begin
            resp_ch.ready <= 1'b0;
            stall_left = (sel < 95) ? $urandom_range(0, 3) : $urandom_range(10, 60);
        end
    end

    always @(posedge clk)
    begin
        term_reply_t exp_reply;
        if (rst_n && resp_ch.valid && resp_ch.ready)
        begin
            if (awaited_replies.size() == 0)
            begin
                $error("response with no request outstanding");
                fail_count++;
            end
            else
            begin
                exp_reply = awaited_replies.pop_front();
                if (resp_ch.cursor_column !== exp_reply.col)
                begin
                    $error("cursor_column expected %0d got %0d",
                           exp_reply.col, resp_ch.cursor_column);
                    fail_count++;
                end
                if (resp_ch.cursor_line !== exp_reply.line)
                begin
                    $error("cursor_line expected %0d got %0d",
                           exp_reply.line, resp_ch.cursor_line);
                    fail_count++;
                end
                if (resp_ch.read_data !== exp_reply.data)
                begin
                    $error("read_data expected %h got %h", exp_reply.data, resp_ch.read_data);
                    fail_count++;
                end
                if (resp_ch.scrolled !== exp_reply.scrolled)
                begin
                    $error("scrolled expected %0d got %0d",
                           exp_reply.scrolled, resp_ch.scrolled);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles where neither side moves a request or response
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        @(posedge rst_n);
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (resp_ch.valid && resp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no request or response moved for %0d cycles", IDLE_LIMIT);
        $display("FAIL text_terminal_writer_unit");
        $finish;
    end

    initial
    begin
        op_t               op;
        logic [CHAR_W-1:0] ch;
        logic [IDX_W-1:0]  idx;
        int                row;
        int                rep;
        int                phase;
        int                n;

        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        req_ch.valid      = 1'b0;
        req_ch.operation  = OP_NONE;
        req_ch.char_code  = '0;
        req_ch.cell_index = '0;
        resp_ch.ready     = 1'b0;
        stall_left        = 0;
        quiet             = 1'b0;
        fail_count        = 0;
        request_count     = 0;
        read_count        = 0;
        scroll_count      = 0;
        clear_count       = 0;
        attr_writes       = 0;
        cur_col           = 0;
        cur_row           = 0;
        attribute         = ATTR_RESET;
        for (n = 0; n < CELL_COUNT; n++)
            screen_copy[n] = {ATTR_RESET, CHAR_BLANK};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (row = 0; row < $size(directed_steps); row++)
            for (rep = 0; rep < directed_steps[row].reps; rep++)
                issue_request(directed_steps[row].op, directed_steps[row].ch,
                              directed_steps[row].idx,
                              directed_steps[row].typed && rep == directed_steps[row].reps - 1,
                              directed_steps[row].want, pick_gap());
        wait_for_replies();

        for (phase = 0; phase < PHASES; phase++)
        begin
            set_attribute(phase_attrs[phase]);
            quiet = (phase % 4 == 2);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                pick_request(op, ch, idx);
                issue_request(op, ch, idx, 1'b0, '0, pick_gap());
            end
            wait_for_replies();
        end

        // catch any late or extra response
        repeat (50) @(posedge clk);

        $display("ran %0d requests: %0d reads, %0d scrolls, %0d clears",
                 request_count, read_count, scroll_count, clear_count);
        $display("attribute register set %0d times, extremes included", attr_writes);
        if (fail_count == 0)
            $display("PASS text_terminal_writer_unit");
        else
            $display("FAIL text_terminal_writer_unit");
        $finish;
    end

endmodule
